FILE: src/uce_pkg.sv
`default_nettype none

package uce_pkg;

	localparam int LEN_W      = 3;
	localparam int PACK_BYTES = 24;
	localparam int EVQ_DEPTH  = 2;

	localparam logic [7:0] BYTE_CONT_MASK = 8'hC0;
	localparam logic [7:0] BYTE_CONT_CODE = 8'h80;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_word;
	} in_word_t;

	typedef struct packed {
		logic [63:0] head_bytes;
		logic [63:0] middle_bytes;
		logic [63:0] tail_bytes;
		logic [4:0]  byte_count;
		logic [2:0]  char_count;
		logic        last_of_word;
		logic        char_truncated;
	} out_word_t;

	// one completed character (or a bare end of word) handed to the back end
	typedef struct packed {
		logic             has_char;
		logic             flag;
		logic             eow;
		logic [LEN_W-1:0] len;
	} evt_ctl_t;

endpackage

`default_nettype wire

FILE: src/uce_front.sv
`default_nettype none

module uce_front #(
	parameter int MAX_CHAR_BYTES = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire uce_pkg::in_word_t           in_data,
	output logic                             evt_push,
	output uce_pkg::evt_ctl_t                evt_ctl,
	output logic [MAX_CHAR_BYTES*8-1:0]      evt_bytes,
	input  wire logic                        q_full
);
	import uce_pkg::*;

	localparam int CB_W = MAX_CHAR_BYTES * 8;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CHAR_BYTES);

	logic [CB_W-1:0]  bld_bytes_q, nxt_bytes;
	logic [LEN_W-1:0] bld_len_q, nxt_len;
	logic             bld_ovf_q, nxt_ovf;
	logic             pend_q, nxt_pend;

	logic             accept;
	logic             is_cont;
	logic             building;
	logic [CB_W-1:0]  lead_bytes;
	logic [CB_W-1:0]  app_bytes;
	logic [CB_W-1:0]  upd_bytes;
	logic [LEN_W-1:0] upd_len;
	logic             upd_ovf;

	assign full     = q_full || pend_q;
	assign accept   = push && !full;
	assign is_cont  = (in_data.in_byte & BYTE_CONT_MASK) == BYTE_CONT_CODE;
	assign building = bld_len_q != '0;

	assign lead_bytes = CB_W'(in_data.in_byte) << (CB_W - 8);
	assign app_bytes  = bld_bytes_q | (lead_bytes >> {bld_len_q, 3'b000});

	always_comb begin
		upd_bytes = bld_bytes_q;
		upd_len   = bld_len_q;
		upd_ovf   = bld_ovf_q;
		if (building) begin
			if (bld_len_q < MAX_LEN) begin
				upd_bytes = app_bytes;
				upd_len   = bld_len_q + 1'b1;
			end else begin
				upd_ovf = 1'b1;
			end
		end
	end

	always_comb begin
		evt_push  = 1'b0;
		evt_ctl   = '0;
		evt_bytes = bld_bytes_q;
		nxt_bytes = bld_bytes_q;
		nxt_len   = bld_len_q;
		nxt_ovf   = bld_ovf_q;
		nxt_pend  = pend_q;
		if (pend_q) begin
			// second half of a word end that closed two characters
			if (!q_full) begin
				evt_push         = 1'b1;
				evt_ctl.has_char = 1'b1;
				evt_ctl.flag     = bld_ovf_q;
				evt_ctl.eow      = 1'b1;
				evt_ctl.len      = bld_len_q;
				nxt_bytes        = '0;
				nxt_len          = '0;
				nxt_ovf          = 1'b0;
				nxt_pend         = 1'b0;
			end
		end else if (accept) begin
			if (is_cont) begin
				if (in_data.end_of_word) begin
					evt_push         = 1'b1;
					evt_ctl.has_char = upd_len != '0;
					evt_ctl.flag     = upd_ovf;
					evt_ctl.eow      = 1'b1;
					evt_ctl.len      = upd_len;
					evt_bytes        = upd_bytes;
					nxt_bytes        = '0;
					nxt_len          = '0;
					nxt_ovf          = 1'b0;
				end else begin
					nxt_bytes = upd_bytes;
					nxt_len   = upd_len;
					nxt_ovf   = upd_ovf;
				end
			end else if (building) begin
				evt_push         = 1'b1;
				evt_ctl.has_char = 1'b1;
				evt_ctl.flag     = bld_ovf_q;
				evt_ctl.eow      = 1'b0;
				evt_ctl.len      = bld_len_q;
				nxt_bytes        = lead_bytes;
				nxt_len          = LEN_W'(1);
				nxt_ovf          = 1'b0;
				nxt_pend         = in_data.end_of_word;
			end else if (in_data.end_of_word) begin
				evt_push         = 1'b1;
				evt_ctl.has_char = 1'b1;
				evt_ctl.flag     = 1'b0;
				evt_ctl.eow      = 1'b1;
				evt_ctl.len      = LEN_W'(1);
				evt_bytes        = lead_bytes;
				nxt_bytes        = '0;
				nxt_len          = '0;
				nxt_ovf          = 1'b0;
			end else begin
				nxt_bytes = lead_bytes;
				nxt_len   = LEN_W'(1);
				nxt_ovf   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bld_len_q <= '0;
			bld_ovf_q <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			bld_len_q <= nxt_len;
			bld_ovf_q <= nxt_ovf;
			pend_q    <= nxt_pend;
		end
	end

	always_ff @(posedge clk) begin
		bld_bytes_q <= nxt_bytes;
	end

	a_pend_has_char: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> bld_len_q != '0)
		else $error("pending word end without a character");

endmodule

`default_nettype wire

FILE: src/uce_fifo.sv
`default_nettype none

module uce_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = count_q == FULL_CNT;
	assign empty   = count_q == '0;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full || rd_en)
		else $error("event queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty)
		else $error("event queue read while empty");

endmodule

`default_nettype wire

FILE: src/uce_back.sv
`default_nettype none

module uce_back #(
	parameter int MAX_GRAM       = 6,
	parameter int MIN_GRAM       = 2,
	parameter int MAX_CHAR_BYTES = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        evt_valid,
	input  wire uce_pkg::evt_ctl_t           evt_ctl,
	input  wire logic [MAX_CHAR_BYTES*8-1:0] evt_bytes,
	output logic                             evt_pop,
	output logic                             empty,
	input  wire logic                        pop,
	output uce_pkg::out_word_t               out_data
);
	import uce_pkg::*;

	localparam int CB_W    = MAX_CHAR_BYTES * 8;
	localparam int CNT_W   = $clog2(MAX_GRAM + 1);
	localparam int IDX_W   = $clog2(MAX_GRAM);
	localparam int POS_W   = $clog2(MAX_GRAM * MAX_CHAR_BYTES + 1);
	localparam int PACK_W  = PACK_BYTES * 8;
	localparam int FIRST_N = (MIN_GRAM < 1) ? 1 : MIN_GRAM;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_GRAM);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t            state_q;
	logic [CB_W-1:0]   win_bytes_q [MAX_GRAM];
	logic [LEN_W-1:0]  win_len_q   [MAX_GRAM];
	logic              win_flag_q  [MAX_GRAM];
	logic [CNT_W-1:0]  held_q;
	logic              eow_q;
	logic [CNT_W-1:0]  n_q;
	logic [PACK_W-1:0] acc_q;
	logic [POS_W-1:0]  pos_q;
	logic              flg_q;
	logic              out_valid_q;
	out_word_t         out_q;

	logic                   out_room;
	logic [IDX_W-1:0]       cur_idx;
	logic [IDX_W-1:0]       wr_idx;
	logic [PACK_W+CB_W-1:0] shifted;
	logic [PACK_W-1:0]      app_acc;
	logic [POS_W-1:0]       app_pos;
	logic                   app_flg;
	logic [CNT_W-1:0]       n1;
	logic                   emit;
	logic                   last_n;
	logic                   is_last;
	logic                   advance;
	logic [CNT_W-1:0]       held_pop;
	logic                   run_after_pop;

	assign out_room = !out_valid_q || pop;
	assign cur_idx  = n_q[IDX_W-1:0];
	assign wr_idx   = held_q[IDX_W-1:0];

	// append the next character of the current start at the running byte offset
	assign shifted = {win_bytes_q[cur_idx], {PACK_W{1'b0}}} >> {pos_q, 3'b000};
	assign app_acc = acc_q | shifted[PACK_W+CB_W-1 -: PACK_W];
	assign app_pos = pos_q + POS_W'(win_len_q[cur_idx]);
	assign app_flg = flg_q | win_flag_q[cur_idx];

	assign n1      = n_q + 1'b1;
	assign emit    = int'(n1) >= FIRST_N;
	assign last_n  = n1 == held_q;
	assign is_last = eow_q && last_n && ((int'(held_q) - 1) < FIRST_N);
	assign advance = (state_q == S_RUN) && (!emit || out_room);

	assign evt_pop       = (state_q == S_IDLE) && evt_valid;
	assign held_pop      = held_q + CNT_W'(evt_ctl.has_char);
	assign run_after_pop = (held_pop == FULL_CNT) || (evt_ctl.eow && held_pop != '0);

	assign empty    = !out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			held_q      <= '0;
			eow_q       <= 1'b0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (evt_valid) begin
						held_q  <= held_pop;
						eow_q   <= evt_ctl.eow;
						n_q     <= '0;
						state_q <= run_after_pop ? S_RUN : S_IDLE;
					end
				end
				S_RUN: begin
					if (advance) begin
						if (last_n) begin
							// start done: drop the oldest character
							held_q  <= held_q - 1'b1;
							n_q     <= '0;
							state_q <= (eow_q && held_q != CNT_W'(1)) ? S_RUN : S_IDLE;
						end else begin
							n_q <= n1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_pop && evt_ctl.has_char) begin
			win_bytes_q[wr_idx] <= evt_bytes;
			win_len_q[wr_idx]   <= evt_ctl.len;
			win_flag_q[wr_idx]  <= evt_ctl.flag;
		end else if (advance && last_n) begin
			for (int i = 0; i < MAX_GRAM - 1; i++) begin
				win_bytes_q[i] <= win_bytes_q[i+1];
				win_len_q[i]   <= win_len_q[i+1];
				win_flag_q[i]  <= win_flag_q[i+1];
			end
		end

		if (evt_pop || (advance && last_n)) begin
			acc_q <= '0;
			pos_q <= '0;
			flg_q <= 1'b0;
		end else if (advance) begin
			acc_q <= app_acc;
			pos_q <= app_pos;
			flg_q <= app_flg;
		end

		if (advance && emit) begin
			out_q.head_bytes     <= app_acc[PACK_W-1 -: 64];
			out_q.middle_bytes   <= app_acc[PACK_W-65 -: 64];
			out_q.tail_bytes     <= app_acc[63:0];
			out_q.byte_count     <= 5'(app_pos);
			out_q.char_count     <= 3'(n1);
			out_q.last_of_word   <= is_last;
			out_q.char_truncated <= app_flg;
		end
	end

	a_run_has_chars: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> held_q != '0 && n_q < held_q)
		else $error("walking a start beyond the held characters");

	a_full_unless_flush: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN && !eow_q |-> held_q == FULL_CNT)
		else $error("window walked without a full window or word end");

	a_idle_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> held_q < FULL_CNT)
		else $error("window full while waiting for a character");

endmodule

`default_nettype wire

FILE: src/utf8_char_ngram_extractor_unit.sv
// UTF-8 character n-gram extractor.
// Input queue port: raise push with in_data (one byte of a word, end_of_word
// on its last byte); the word is taken when full is low. Output queue port:
// while empty is low out_data holds the oldest n-gram, removed by pop.
// Bytes are grouped into characters; every run of MIN_GRAM..MAX_GRAM
// characters comes out, by start character and then by growing length.
// last_of_word marks the final n-gram of a word; short words give nothing.
// A front end assembles characters and queues them; the back end keeps a
// window of MAX_GRAM characters and builds each n-gram by appending one
// character per cycle, while the result register has room, to a running
// byte buffer. At the defaults a character that fills the window is loaded
// and then walked in six appends, five of them giving results; a character
// that leaves the window short is only loaded, and the word end adds a walk
// for each held start. A stalled pop holds the result register and the
// back end; the front keeps taking bytes until the two-entry character
// queue fills. Reset empties the queue, the window and the result register.
`default_nettype none

module utf8_char_ngram_extractor_unit #(
	parameter int MAX_GRAM       = 6,
	parameter int MIN_GRAM       = 2,
	parameter int MAX_CHAR_BYTES = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire uce_pkg::in_word_t  in_data,
	output logic                    empty,
	input  wire logic               pop,
	output uce_pkg::out_word_t      out_data
);
	import uce_pkg::*;

	localparam int CB_W  = MAX_CHAR_BYTES * 8;
	localparam int EVT_W = $bits(evt_ctl_t) + CB_W;

	logic            evt_push;
	evt_ctl_t        evt_ctl_wr;
	logic [CB_W-1:0] evt_bytes_wr;
	logic            q_full;
	logic            q_empty;
	logic            evt_pop;
	logic [EVT_W-1:0] q_rd;
	evt_ctl_t        evt_ctl_rd;
	logic [CB_W-1:0] evt_bytes_rd;

	assign evt_ctl_rd   = q_rd[EVT_W-1 -: $bits(evt_ctl_t)];
	assign evt_bytes_rd = q_rd[CB_W-1:0];

	uce_front #(
		.MAX_CHAR_BYTES(MAX_CHAR_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_data  (in_data),
		.evt_push (evt_push),
		.evt_ctl  (evt_ctl_wr),
		.evt_bytes(evt_bytes_wr),
		.q_full   (q_full)
	);

	uce_fifo #(
		.WIDTH(EVT_W),
		.DEPTH(EVQ_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (evt_push),
		.wr_data({evt_ctl_wr, evt_bytes_wr}),
		.full   (q_full),
		.rd_en  (evt_pop),
		.rd_data(q_rd),
		.empty  (q_empty)
	);

	uce_back #(
		.MAX_GRAM      (MAX_GRAM),
		.MIN_GRAM      (MIN_GRAM),
		.MAX_CHAR_BYTES(MAX_CHAR_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt_valid(!q_empty),
		.evt_ctl  (evt_ctl_rd),
		.evt_bytes(evt_bytes_rd),
		.evt_pop  (evt_pop),
		.empty    (empty),
		.pop      (pop),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import uce_pkg::*;

	localparam int MAX_GRAM   = 6;
	localparam int MIN_GRAM   = 2;
	localparam int CHAR_BYTES = 4;
	localparam int RAND_BYTES = 245;
	localparam int END_DRAIN  = 40;
	localparam int LIMIT      = 1_000_000;

	typedef struct {
		in_word_t w;
		bit       hold;
	} byte_req_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_word_t  in_data = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_word_t out_data;

	utf8_char_ngram_extractor_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_data(in_data),
		.empty(empty),
		.pop(pop),
		.out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	byte_req_t byte_backlog[$];
	out_word_t ngram_expected[$];
	int        byte_total = 0;
	int        errors = 0;
	int        cycle_count = 0;

	// predictor state: held characters, the one being assembled
	logic [7:0] win_byte[MAX_GRAM][CHAR_BYTES];
	int         win_len[MAX_GRAM];
	bit         win_trunc[MAX_GRAM];
	int         n_held = 0;
	logic [7:0] cur_byte[CHAR_BYTES];
	int         cur_len = 0;
	bit         cur_trunc = 1'b0;
	out_word_t  step_grams[$];

	function automatic out_word_t pack_gram(int first, int n);
		logic [8*PACK_BYTES-1:0] flat;
		out_word_t               g;
		int                      pos;
		flat = '0;
		g = '0;
		pos = 0;
		for (int c = first; c < first + n; c++) begin
			g.char_truncated |= win_trunc[c];
			for (int b = 0; b < win_len[c]; b++) begin
				flat[8*PACK_BYTES-1-8*pos -: 8] = win_byte[c][b];
				pos++;
			end
		end
		g.head_bytes   = flat[191:128];
		g.middle_bytes = flat[127:64];
		g.tail_bytes   = flat[63:0];
		g.byte_count   = pos[4:0];
		g.char_count   = n[2:0];
		return g;
	endfunction

	function automatic void grams_from(int first, int avail);
		for (int n = MIN_GRAM; n <= avail && n <= MAX_GRAM; n++)
			step_grams.insert(step_grams.size(), pack_gram(first, n));
	endfunction

	function automatic void close_char();
		if (n_held < MAX_GRAM) begin
			for (int b = 0; b < CHAR_BYTES; b++)
				win_byte[n_held][b] = cur_byte[b];
			win_len[n_held] = cur_len;
			win_trunc[n_held] = cur_trunc;
			n_held++;
		end
		// a full window releases its oldest start, then slides
		if (n_held >= MAX_GRAM) begin
			grams_from(0, MAX_GRAM);
			for (int i = 0; i + 1 < MAX_GRAM; i++) begin
				for (int b = 0; b < CHAR_BYTES; b++)
					win_byte[i][b] = win_byte[i+1][b];
				win_len[i] = win_len[i+1];
				win_trunc[i] = win_trunc[i+1];
			end
			n_held = MAX_GRAM - 1;
		end
		for (int b = 0; b < CHAR_BYTES; b++)
			cur_byte[b] = 8'h00;
		cur_len = 0;
		cur_trunc = 1'b0;
	endfunction

	function automatic void clear_word();
		for (int i = 0; i < MAX_GRAM; i++) begin
			for (int b = 0; b < CHAR_BYTES; b++)
				win_byte[i][b] = 8'h00;
			win_len[i] = 0;
			win_trunc[i] = 1'b0;
		end
		for (int b = 0; b < CHAR_BYTES; b++)
			cur_byte[b] = 8'h00;
		n_held = 0;
		cur_len = 0;
		cur_trunc = 1'b0;
	endfunction

	function automatic void ngram_predict(in_word_t w);
		step_grams.delete();
		if ((w.in_byte & BYTE_CONT_MASK) == BYTE_CONT_CODE) begin
			// stray continuations are dropped, extra ones only flag the character
			if (cur_len > 0) begin
				if (cur_len < CHAR_BYTES) begin
					cur_byte[cur_len] = w.in_byte;
					cur_len++;
				end else begin
					cur_trunc = 1'b1;
				end
			end
		end else begin
			if (cur_len > 0)
				close_char();
			cur_byte[0] = w.in_byte;
			cur_len = 1;
		end
		if (w.end_of_word) begin
			if (cur_len > 0)
				close_char();
			for (int s = 0; s < n_held; s++)
				grams_from(s, n_held - s);
			if (step_grams.size() > 0)
				step_grams[step_grams.size()-1].last_of_word = 1'b1;
			clear_word();
		end
		foreach (step_grams[i])
			ngram_expected.insert(ngram_expected.size(), step_grams[i]);
	endfunction

	task automatic add_byte(logic [7:0] b, bit eow, bit hold = 1'b0);
		byte_req_t r;
		r.w.in_byte = b;
		r.w.end_of_word = eow;
		r.hold = hold;
		byte_backlog.insert(byte_backlog.size(), r);
		byte_total++;
	endtask

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	// mostly well-formed UTF-8; noisy words mix in stray and arbitrary bytes
	task automatic add_word(bit noisy, bit hold_first);
		logic [7:0] seq[$];
		int         n_chars;
		int         kind;
		n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
		if (noisy && $urandom_range(0, 1) == 1)
			repeat ($urandom_range(1, 3)) seq.insert(seq.size(), cont_byte());
		for (int i = 0; i < n_chars; i++) begin
			if (noisy && $urandom_range(0, 2) == 0) begin
				seq.insert(seq.size(), 8'($urandom));
			end else begin
				kind = $urandom_range(0, 19);
				if (kind < 8) begin
					seq.insert(seq.size(), 8'($urandom_range(0, 127)));
				end else if (kind < 12) begin
					seq.insert(seq.size(), {3'b110, 5'($urandom)});
					seq.insert(seq.size(), cont_byte());
				end else if (kind < 16) begin
					seq.insert(seq.size(), {4'b1110, 4'($urandom)});
					repeat (2) seq.insert(seq.size(), cont_byte());
				end else if (kind < 19) begin
					seq.insert(seq.size(), {5'b11110, 3'($urandom)});
					repeat (3) seq.insert(seq.size(), cont_byte());
				end else begin
					seq.insert(seq.size(), {5'b11111, 3'($urandom)});
					repeat ($urandom_range(4, 6)) seq.insert(seq.size(), cont_byte());
				end
			end
		end
		foreach (seq[i])
			add_byte(seq[i], i == seq.size() - 1, hold_first && i == 0);
	endtask

	function automatic int pick_gap(bit idle_on);
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// handshake bookkeeping shared between sample and drive edges
	int in_taken = 0;
	int out_taken = 0;
	int in_seen = 0;
	int out_seen = 0;
	int in_gap = 0;
	int out_gap = 0;
	bit in_idle_on = 1'b1;
	bit out_idle_on = 1'b1;

	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			pop <= 1'b0;
		end else begin
			if (in_taken != in_seen) begin
				in_seen = in_taken;
				in_gap = pick_gap(in_idle_on);
				if ($urandom_range(0, 29) == 0)
					in_idle_on = !in_idle_on;
			end
			// hold the byte during a gap, with an empty backlog, or while a pause for a full drain is pending
			if (in_gap > 0) begin
				in_gap--;
				push <= 1'b0;
			end else if (byte_backlog.size() == 0 ||
			             (byte_backlog[0].hold && ngram_expected.size() != 0)) begin
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				in_data <= byte_backlog[0].w;
			end

			if (out_taken != out_seen) begin
				out_seen = out_taken;
				out_gap = pick_gap(out_idle_on);
				if ($urandom_range(0, 29) == 0)
					out_idle_on = !out_idle_on;
			end
			if (out_gap > 0) begin
				out_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		out_word_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				out_taken++;
				if (ngram_expected.size() == 0) begin
					errors++;
					$error("unexpected n-gram: head_bytes %h byte_count %0d",
					       out_data.head_bytes, out_data.byte_count);
				end else begin
					e = ngram_expected.pop_front();
					if (out_data.head_bytes !== e.head_bytes) begin
						errors++;
						$error("head_bytes: expected %h, got %h", e.head_bytes, out_data.head_bytes);
					end
					if (out_data.middle_bytes !== e.middle_bytes) begin
						errors++;
						$error("middle_bytes: expected %h, got %h",
						       e.middle_bytes, out_data.middle_bytes);
					end
					if (out_data.tail_bytes !== e.tail_bytes) begin
						errors++;
						$error("tail_bytes: expected %h, got %h", e.tail_bytes, out_data.tail_bytes);
					end
					if (out_data.byte_count !== e.byte_count) begin
						errors++;
						$error("byte_count: expected %0d, got %0d", e.byte_count, out_data.byte_count);
					end
					if (out_data.char_count !== e.char_count) begin
						errors++;
						$error("char_count: expected %0d, got %0d", e.char_count, out_data.char_count);
					end
					if (out_data.last_of_word !== e.last_of_word) begin
						errors++;
						$error("last_of_word: expected %0b, got %0b",
						       e.last_of_word, out_data.last_of_word);
					end
					if (out_data.char_truncated !== e.char_truncated) begin
						errors++;
						$error("char_truncated: expected %0b, got %0b",
						       e.char_truncated, out_data.char_truncated);
					end
				end
			end
			if (push && !full) begin
				ngram_predict(byte_backlog[0].w);
				void'(byte_backlog.pop_front());
				in_taken++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int rand_start;
		clear_word();

		// single character: nothing comes out
		add_byte(8'h41, 1'b1);
		// byte extremes as a two-character word
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b1);
		// stray leading continuations are dropped
		add_byte(8'h80, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'h61, 1'b0);
		add_byte(8'h62, 1'b1);
		// over-long character is cut to four bytes and flagged
		add_byte(8'hF8, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'h81, 1'b0);
		add_byte(8'h82, 1'b0);
		add_byte(8'h83, 1'b0);
		add_byte(8'h84, 1'b0);
		add_byte(8'h7A, 1'b1);
		// seven characters: window fills and slides before the word end
		for (int i = 0; i < 7; i++)
			add_byte(8'h61 + 8'(i), i == 6);
		// word of only a stray continuation
		add_byte(8'h9F, 1'b1);
		// word ends on a continuation byte
		add_byte(8'h78, 1'b0);
		add_byte(8'hC3, 1'b0);
		add_byte(8'hA9, 1'b1);

		rand_start = byte_total;
		add_word(1'b0, 1'b1);
		while (byte_total - rand_start < RAND_BYTES)
			add_word($urandom_range(0, 6) == 0,
			         byte_total - rand_start >= RAND_BYTES / 2 &&
			         byte_total - rand_start < RAND_BYTES / 2 + 6);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_backlog.size() != 0 || ngram_expected.size() != 0)
			@(posedge clk);
		repeat (END_DRAIN) @(posedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
